// ===== rtl/core/stepper_position_homing_controller_top_assert.svh =====
// Assertion macros for the stepper position homing controller.
// Expects signals named clk and rst in the scope of each use.
`ifndef STEPPER_POSITION_HOMING_CONTROLLER_TOP_ASSERT_SVH
`define STEPPER_POSITION_HOMING_CONTROLLER_TOP_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SPHC_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("sphc assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define SPHC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("sphc assertion failed");

`endif

// ===== rtl/core/sphc_pkg.sv =====
// Shared types and constants of the stepper position homing controller.
// No dependencies.
package sphc_pkg;

  typedef enum logic [1:0] {
    ACT_TICK     = 2'd0,
    ACT_MOVE_ABS = 2'd1,
    ACT_MOVE_REL = 2'd2,
    ACT_HOME     = 2'd3
  } action_t;

  typedef enum logic {
    REG_STEP_INTERVAL = 1'b0,
    REG_PHASE_TABLE   = 1'b1
  } reg_index_t;

  localparam int unsigned IntervalWidth = 20;
  localparam int unsigned PosWidth      = 32;
  localparam int unsigned CfgWidth      = 32;
  localparam int unsigned InDataWidth   = 40;
  localparam int unsigned OutDataWidth  = 40;

  localparam logic [IntervalWidth-1:0] ElapsedMax        = '1;
  localparam logic [IntervalWidth-1:0] StepIntervalReset = 20'd1000;
  localparam logic [CfgWidth-1:0]      PhaseTableReset   = 32'h98C46231;

  typedef struct packed {
    logic                stepped;
    logic                homing;
    logic                homed;
    logic                busy_res;
    logic [PosWidth-1:0] current_position;
    logic [3:0]          coils;
  } result_t;

endpackage

// ===== rtl/core/stepper_position_homing_controller_top.sv =====
// Top level of the stepper position homing controller: state update,
// result register and skid stage. Depends on sphc_pkg and the assertion header.
//
// channel  direction  payload
// s_axis   in         tuser: action[1:0]; tdata: position[31:0], limit_level[32]
// m_axis   out        tdata: coils, current_position, busy_res, homed, homing, stepped
// cfg      in         cfg_we, cfg_index (0 step_interval, 1 phase_table), cfg_data
//
// The controller state updates at the accepting edge, and the result is registered
// into the output register at that edge, or into the skid stage while the output stalls.
// One item per clock is sustained while the output side takes results.
// A one-entry skid stage holds a result while the output stalls; input ready
// drops only while that stage is full.
// rst is synchronous and restores the register and state reset values.
`include "stepper_position_homing_controller_top_assert.svh"

module stepper_position_homing_controller_top (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  s_tvalid,
  output logic                                  s_tready,
  // tdata: position[31:0], limit_level[32], zero fill [39:33]
  input  logic [sphc_pkg::InDataWidth-1:0]      s_tdata,
  // tuser: action[1:0]
  input  logic [1:0]                            s_tuser,
  output logic                                  m_tvalid,
  input  logic                                  m_tready,
  // tdata: coils[3:0], current_position[35:4], busy_res[36], homed[37],
  // homing[38], stepped[39]
  output logic [sphc_pkg::OutDataWidth-1:0]     m_tdata,
  input  logic                                  cfg_we,
  input  logic                                  cfg_index,
  input  logic [sphc_pkg::CfgWidth-1:0]         cfg_data
);
  import sphc_pkg::*;

  logic [IntervalWidth-1:0] step_interval;
  logic [CfgWidth-1:0]      phase_table;

  logic [PosWidth-1:0]      position_count, position_count_next;
  logic [PosWidth-1:0]      target_count, target_count_next;
  logic [2:0]               phase_index, phase_index_next;
  logic                     homed_flag, homed_flag_next;
  logic                     homing_flag, homing_flag_next;
  logic [IntervalWidth-1:0] ticks_elapsed, ticks_elapsed_next;
  logic                     stepped;

  logic    out_valid, skid_valid;
  result_t out_res, skid_res, new_res;

  action_t             action;
  logic [PosWidth-1:0] arg;
  logic                limit_hit;
  logic                accept;
  logic [IntervalWidth-1:0] elapsed_inc;
  logic                interval_met;
  logic                backward;

  assign action    = action_t'(s_tuser);
  assign arg       = s_tdata[PosWidth-1:0];
  assign limit_hit = ~s_tdata[PosWidth];
  assign s_tready  = ~skid_valid;
  assign accept    = s_tvalid & s_tready;

  assign elapsed_inc  = (ticks_elapsed != ElapsedMax) ? ticks_elapsed + 1'b1 : ticks_elapsed;
  assign interval_met = (elapsed_inc >= step_interval);
  assign backward     = ($signed(target_count) < $signed(position_count));

  always_comb begin
    position_count_next = position_count;
    target_count_next   = target_count;
    phase_index_next    = phase_index;
    homed_flag_next     = homed_flag;
    homing_flag_next    = homing_flag;
    ticks_elapsed_next  = ticks_elapsed;
    stepped             = 1'b0;
    unique case (action)
      ACT_TICK: begin
        ticks_elapsed_next = elapsed_inc;
        if (homing_flag) begin
          if (limit_hit) begin
            position_count_next = '0;
            target_count_next   = '0;
            homed_flag_next     = 1'b1;
            homing_flag_next    = 1'b0;
          end else if (interval_met) begin
            ticks_elapsed_next = '0;
            phase_index_next   = phase_index - 3'd1;
            stepped            = 1'b1;
          end
        end else if (position_count != target_count) begin
          // During a move, a limit hit is only honored while moving backward.
          if (backward && limit_hit) begin
            position_count_next = '0;
            target_count_next   = '0;
            homed_flag_next     = 1'b1;
          end else if (interval_met) begin
            ticks_elapsed_next = '0;
            stepped            = 1'b1;
            if (backward) begin
              position_count_next = position_count - 1'b1;
              phase_index_next    = phase_index - 3'd1;
            end else begin
              position_count_next = position_count + 1'b1;
              phase_index_next    = phase_index + 3'd1;
            end
          end
        end
      end
      ACT_MOVE_ABS: begin
        if (!homing_flag) target_count_next = arg;
      end
      ACT_MOVE_REL: begin
        if (!homing_flag) target_count_next = position_count + arg;
      end
      ACT_HOME: begin
        homing_flag_next = 1'b1;
        if (limit_hit) begin
          position_count_next = '0;
          target_count_next   = '0;
          homed_flag_next     = 1'b1;
          homing_flag_next    = 1'b0;
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    new_res.coils            = phase_table[{phase_index_next, 2'b00} +: 4];
    new_res.current_position = position_count_next;
    new_res.busy_res         = (position_count_next != target_count_next);
    new_res.homed            = homed_flag_next;
    new_res.homing           = homing_flag_next;
    new_res.stepped          = stepped;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step_interval <= StepIntervalReset;
      phase_table   <= PhaseTableReset;
    end else if (cfg_we) begin
      unique case (reg_index_t'(cfg_index))
        REG_STEP_INTERVAL: step_interval <= cfg_data[IntervalWidth-1:0];
        REG_PHASE_TABLE:   phase_table   <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      position_count <= '0;
      target_count   <= '0;
      phase_index    <= '0;
      homed_flag     <= 1'b0;
      homing_flag    <= 1'b0;
      ticks_elapsed  <= ElapsedMax;
    end else if (accept) begin
      position_count <= position_count_next;
      target_count   <= target_count_next;
      phase_index    <= phase_index_next;
      homed_flag     <= homed_flag_next;
      homing_flag    <= homing_flag_next;
      ticks_elapsed  <= ticks_elapsed_next;
    end
  end

  // Output register with a one-entry skid stage behind it.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      if (!out_valid || m_tready) begin
        out_valid  <= skid_valid | accept;
        skid_valid <= 1'b0;
      end else if (accept) begin
        skid_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || m_tready) begin
      out_res <= skid_valid ? skid_res : new_res;
    end else if (accept) begin
      skid_res <= new_res;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = out_res;

  `SPHC_ASSERT_SAME(a_skid_behind_out, skid_valid, out_valid)
  `SPHC_ASSERT_NEXT(a_stall_holds, out_valid && !m_tready, out_valid)
  `SPHC_ASSERT_SAME(a_homing_ends_homed, $fell(homing_flag), homed_flag)
  `SPHC_ASSERT_SAME(a_homed_zeroes, $rose(homed_flag),
                    position_count == '0 && target_count == '0)

endmodule
